@@ rtl/core/ocr_pkg.sv @@
// package for the orbit camera rotate unit
// constants, angle table and command codes; no dependencies
package ocr_pkg;
  localparam int CordicStepsDef = 16;
  localparam int FracBitsDef = 16;
  localparam int TabLen = 24;
  localparam logic signed [16:0] Turn = 17'sd46080;
  localparam logic signed [16:0] HalfTurn = 17'sd23040;
  localparam logic signed [16:0] Quarter = 17'sd11520;
  localparam logic signed [16:0] ThreeQuarter = 17'sd34560;
  localparam longint GainQ30 = 64'd652032874;

  localparam logic CmdRotate = 1'b0;
  localparam logic CmdReload = 1'b1;

  localparam logic [2:0] RegTargetX = 3'd0;
  localparam logic [2:0] RegTargetY = 3'd1;
  localparam logic [2:0] RegTargetZ = 3'd2;
  localparam logic [2:0] RegRadius = 3'd3;
  localparam logic [2:0] RegStartEl = 3'd4;
  localparam logic [2:0] RegStartAz = 3'd5;

  // atan(2^-i) in degrees, scaled by 2^16
  function automatic logic [22:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 23'd2949120;
      5'd1: atan_lut = 23'd1740967;
      5'd2: atan_lut = 23'd919879;
      5'd3: atan_lut = 23'd466945;
      5'd4: atan_lut = 23'd234379;
      5'd5: atan_lut = 23'd117304;
      5'd6: atan_lut = 23'd58666;
      5'd7: atan_lut = 23'd29335;
      5'd8: atan_lut = 23'd14668;
      5'd9: atan_lut = 23'd7334;
      5'd10: atan_lut = 23'd3667;
      5'd11: atan_lut = 23'd1833;
      5'd12: atan_lut = 23'd917;
      5'd13: atan_lut = 23'd458;
      5'd14: atan_lut = 23'd229;
      5'd15: atan_lut = 23'd115;
      5'd16: atan_lut = 23'd57;
      5'd17: atan_lut = 23'd29;
      5'd18: atan_lut = 23'd14;
      5'd19: atan_lut = 23'd7;
      5'd20: atan_lut = 23'd4;
      5'd21: atan_lut = 23'd2;
      5'd22: atan_lut = 23'd1;
      default: atan_lut = 23'd0;
    endcase
  endfunction
endpackage

@@ rtl/core/orbit_camera_rotate_unit.sv @@
// orbit camera rotate unit, top level
// one shared cordic stage and one shared multiplier under a sequencer; uses ocr_pkg
//
// input channel (in_valid_i/in_ready_o): command, axis, delta_angle
// output channel (out_valid_o/out_ready_i): accepted, moved, pos, up_y
// config channel (cfg_valid_i/cfg_ready_o): register index and data, always ready
// a transfer on the input starts one item; the unit is not ready again until
// the result has left the output register
// path from the input transfer to out_valid_o: StPrep and the cordic loop
// for elevation, then again for azimuth (one shared stage), then StMulRc,
// StMulX, StMulZ and StMulY on the shared multiplier, then compare and writeback in StDone
// items do not overlap: the next input transfer waits for the result transfer
// rotates on an invalid axis skip the arithmetic: the sequencer goes straight to StDone
// reset: angles and position zero, up sign +1, targets 0, radius 1.0
// a stalled receiver holds the result; a new item is taken only once the
// output register is free again
module orbit_camera_rotate_unit
  import ocr_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [1:0]         axis_i,
  input  logic signed [16:0] delta_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic               moved_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [1:0]  up_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  // cordic word: z in deg*2^16 needs 24 bits; x,y need FRAC_BITS+2
  localparam int CW = FRAC_BITS + 2;
  localparam int SW = $clog2(CORDIC_STEPS + 1);
  localparam logic [CW-1:0] Gain = CW'(GainQ30 >>> (30 - FRAC_BITS));

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StPrep  = 8'b0000_0010,
    StCord  = 8'b0000_0100,
    StMulRc = 8'b0000_1000,
    StMulX  = 8'b0001_0000,
    StMulZ  = 8'b0010_0000,
    StMulY  = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] tgt_x_q, tgt_y_q, tgt_z_q;
  logic [30:0]        radius_q;
  logic signed [16:0] start_el_q, start_az_q;
  logic signed [16:0] elev_q, azim_q, new_el_q, new_az_q;
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic signed [1:0]  up_q;
  logic               reload_q, valid_axis_q;

  // cordic working registers
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [24:0]   cz_q;
  logic [SW-1:0]        step_q;
  logic                 pass_q;   // 0 elevation, 1 azimuth
  logic                 neg_q;
  logic signed [CW-1:0] se_q, ce_q, sa_q, ca_q;
  logic signed [47:0]   rc_q;
  logic signed [31:0]   px_q, py_q, pz_q;

  logic out_valid_q, accepted_q, moved_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign accepted_o = accepted_q;
  assign moved_o = moved_q;
  assign pos_x_o = cam_x_q;
  assign pos_y_o = cam_y_q;
  assign pos_z_o = cam_z_q;
  assign up_y_o = up_q;

  // angle reduction to [-90,90] with sign flag
  logic signed [16:0] red_ang, red_r;
  logic signed [17:0] red_m;
  logic               red_neg;
  always_comb begin
    red_ang = pass_q ? new_az_q : new_el_q;
    red_m = 18'(red_ang);
    if (red_m >= 18'(HalfTurn)) red_m = red_m - 18'(Turn);
    if (red_m < -18'(HalfTurn)) red_m = red_m + 18'(Turn);
    red_neg = 1'b0;
    if (red_m > 18'(Quarter)) begin
      red_m = red_m - 18'(HalfTurn);
      red_neg = 1'b1;
    end else if (red_m < -18'(Quarter)) begin
      red_m = red_m + 18'(HalfTurn);
      red_neg = 1'b1;
    end
    red_r = red_m[16:0];
  end

  // shared cordic stage
  logic signed [CW-1:0] dx, dy;
  logic signed [24:0]   at;
  always_comb begin
    dx = cy_q >>> step_q;
    dy = cx_q >>> step_q;
    at = 25'(atan_lut(5'(step_q)));
  end

  // shared multiplier: 48 bit operand by sine/cosine
  logic signed [47:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [48+CW-1:0] mul_p, mul_r;
  always_comb begin
    mul_a = 48'(signed'({1'b0, radius_q}));
    mul_b = ce_q;
    case (state_q)
      StMulRc: begin mul_a = 48'(signed'({1'b0, radius_q})); mul_b = ce_q; end
      StMulX:  begin mul_a = rc_q; mul_b = sa_q; end
      StMulZ:  begin mul_a = rc_q; mul_b = ca_q; end
      StMulY:  begin mul_a = 48'(signed'({1'b0, radius_q})); mul_b = se_q; end
      default: ;
    endcase
    mul_p = (48+CW)'(mul_a) * (48+CW)'(mul_b);
    mul_r = (mul_p + (48+CW)'(1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  function automatic logic signed [31:0] sat(input logic signed [48+CW:0] v);
    if (v > (48+CW+1)'(32'sh7fffffff)) sat = 32'sh7fffffff;
    else if (v < -(48+CW+1)'(33'sh080000000)) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction

  function automatic logic signed [1:0] up_for(input logic signed [16:0] e);
    if ((e <= -Quarter && e >= -ThreeQuarter) || (e >= Quarter && e <= ThreeQuarter))
      up_for = -2'sd1;
    else up_for = 2'sd1;
  endfunction

  // angle sum with one wrap
  logic signed [17:0] sum;
  logic signed [16:0] sum_w;
  always_comb begin
    sum = 18'(axis_i[0] ? azim_q : elev_q) + 18'(delta_angle_i);
    if (sum < -18'(Turn)) sum = sum + 18'(Turn);
    else if (sum > 18'(Turn)) sum = sum - 18'(Turn);
    sum_w = sum[16:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i && in_ready_o) state_d =
                 (command_i == CmdReload || !axis_i[1]) ? StPrep : StDone;
      StPrep:  state_d = StCord;
      StCord:  if (step_q == SW'(CORDIC_STEPS - 1)) state_d = pass_q ? StMulRc : StPrep;
      StMulRc: state_d = StMulX;
      StMulX:  state_d = StMulZ;
      StMulZ:  state_d = StMulY;
      StMulY:  state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tgt_x_q <= '0; tgt_y_q <= '0; tgt_z_q <= '0;
      radius_q <= 31'd65536;
      start_el_q <= '0; start_az_q <= '0;
      elev_q <= '0; azim_q <= '0;
      cam_x_q <= '0; cam_y_q <= '0; cam_z_q <= '0;
      up_q <= 2'sd1;
      out_valid_q <= 1'b0;
      pass_q <= 1'b0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegTargetX: tgt_x_q <= cfg_data_i;
          RegTargetY: tgt_y_q <= cfg_data_i;
          RegTargetZ: tgt_z_q <= cfg_data_i;
          RegRadius:  radius_q <= cfg_data_i[30:0];
          RegStartEl: start_el_q <= cfg_data_i[16:0];
          RegStartAz: start_az_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i && in_ready_o) begin
          reload_q <= command_i;
          valid_axis_q <= !axis_i[1];
          pass_q <= 1'b0;
          if (command_i == CmdReload) begin
            new_el_q <= start_el_q; new_az_q <= start_az_q;
          end else begin
            new_el_q <= axis_i[0] ? elev_q : sum_w;
            new_az_q <= axis_i[0] ? sum_w : azim_q;
          end
        end
        StPrep: begin
          cx_q <= signed'(Gain);
          cy_q <= '0;
          cz_q <= 25'(red_r) * 25'sd512;
          neg_q <= red_neg;
          step_q <= '0;
        end
        StCord: begin
          if (!cz_q[24]) begin
            cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - at;
          end else begin
            cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + at;
          end
          step_q <= step_q + 1'b1;
          if (step_q == SW'(CORDIC_STEPS - 1)) begin
            pass_q <= 1'b1;
            if (!pass_q) begin
              se_q <= neg_q ? -(!cz_q[24] ? cy_q + dy : cy_q - dy) :
                               (!cz_q[24] ? cy_q + dy : cy_q - dy);
              ce_q <= neg_q ? -(!cz_q[24] ? cx_q - dx : cx_q + dx) :
                               (!cz_q[24] ? cx_q - dx : cx_q + dx);
            end else begin
              sa_q <= neg_q ? -(!cz_q[24] ? cy_q + dy : cy_q - dy) :
                               (!cz_q[24] ? cy_q + dy : cy_q - dy);
              ca_q <= neg_q ? -(!cz_q[24] ? cx_q - dx : cx_q + dx) :
                               (!cz_q[24] ? cx_q - dx : cx_q + dx);
            end
          end
        end
        StMulRc: rc_q <= mul_r[47:0];
        StMulX:  px_q <= sat((48+CW+1)'(tgt_x_q) + (48+CW+1)'(mul_r));
        StMulZ:  pz_q <= sat((48+CW+1)'(tgt_z_q) + (48+CW+1)'(mul_r));
        StMulY:  py_q <= sat((48+CW+1)'(tgt_y_q) - (48+CW+1)'(mul_r));
        StDone: begin
          out_valid_q <= 1'b1;
          accepted_q <= reload_q || valid_axis_q;
          moved_q <= 1'b0;
          if (reload_q || (valid_axis_q && (px_q != tgt_x_q || pz_q != tgt_z_q))) begin
            moved_q <= 1'b1;
            cam_x_q <= px_q; cam_y_q <= py_q; cam_z_q <= pz_q;
            elev_q <= new_el_q; azim_q <= new_az_q;
            up_q <= up_for(new_el_q);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ test/orbit_camera_rotate_unit_tb.sv @@
// self-checking testbench for orbit_camera_rotate_unit
// predicts each result from a local fixed-point model of the orbit camera; uses ocr_pkg
module orbit_camera_rotate_unit_tb;
  import ocr_pkg::*;

  localparam int Steps = 16;
  localparam int Frac = 16;

  typedef struct packed {
    logic               accepted;
    logic               moved;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [1:0]  up_y;
  } pose_t;

  // scoreboard: own copy of camera state and registers, queue of pending poses
  class pose_board;
    longint tgt_x, tgt_y, tgt_z, radius, start_el, start_az;
    longint elev, azim, cx, cy, cz, up;
    pose_t pending[$];
    int errors;
    int checked;

    function new();
      tgt_x = 0; tgt_y = 0; tgt_z = 0; radius = 65536; start_el = 0; start_az = 0;
      elev = 0; azim = 0; cx = 0; cy = 0; cz = 0; up = 1;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        RegTargetX: tgt_x = longint'($signed(data));
        RegTargetY: tgt_y = longint'($signed(data));
        RegTargetZ: tgt_z = longint'($signed(data));
        RegRadius:  radius = longint'(data[30:0]);
        RegStartEl: start_el = longint'($signed(data[16:0]));
        RegStartAz: start_az = longint'($signed(data[16:0]));
        default: ;
      endcase
    endfunction

    function longint fl_shift(longint v, int s);
      return v >>> s;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void trig(longint ang, output longint s, output longint c);
      longint r, x, y, z, dx, dy;
      bit neg;
      r = ang % 46080;
      neg = 0;
      y = 0;
      if (r >= 23040) r -= 46080;
      if (r < -23040) r += 46080;
      if (r > 11520) begin
        r -= 23040; neg = 1;
      end else if (r < -11520) begin
        r += 23040; neg = 1;
      end
      z = r * 512;
      x = GainQ30 >>> (30 - Frac);
      for (int i = 0; i < Steps && i < TabLen; i++) begin
        dx = fl_shift(y, i);
        dy = fl_shift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
        end
      end
      s = neg ? -y : y;
      c = neg ? -x : x;
    endfunction

    function longint mulq(longint a, longint b);
      return fl_shift(a * b + (64'sd1 <<< (Frac - 1)), Frac);
    endfunction

    function void orbit_point(longint el, longint az,
                              output longint px, output longint py, output longint pz);
      longint se, ce, sa, ca, rc;
      trig(el, se, ce);
      trig(az, sa, ca);
      rc = mulq(radius, ce);
      px = sat(tgt_x + mulq(rc, sa));
      py = sat(tgt_y - mulq(radius, se));
      pz = sat(tgt_z + mulq(rc, ca));
    endfunction

    function longint up_of(longint el);
      if (el <= -11520 && el >= -34560) return -1;
      if (el >= 11520 && el <= 34560) return -1;
      return 1;
    endfunction

    // note an accepted input transfer and queue its expected pose
    function void note_command(logic cmd, logic [1:0] ax, logic signed [16:0] delta);
      pose_t p;
      longint el, az, sum, px, py, pz;
      logic [16:0] wrapped;
      p.accepted = 0;
      p.moved = 0;
      if (cmd == CmdReload) begin
        p.accepted = 1; p.moved = 1;
        elev = start_el; azim = start_az;
        orbit_point(elev, azim, cx, cy, cz);
        up = up_of(elev);
      end else if (ax < 2) begin
        el = elev; az = azim;
        sum = (ax == 0 ? el : az) + longint'(delta);
        if (sum < -46080) sum += 46080;
        else if (sum > 46080) sum -= 46080;
        wrapped = sum[16:0];
        sum = longint'($signed(wrapped));
        if (ax == 0) el = sum; else az = sum;
        p.accepted = 1;
        orbit_point(el, az, px, py, pz);
        // straight overhead: pose kept unchanged
        if (px != tgt_x || pz != tgt_z) begin
          p.moved = 1;
          cx = px; cy = py; cz = pz; elev = el; azim = az;
          up = up_of(elev);
        end
      end
      p.pos_x = cx[31:0];
      p.pos_y = cy[31:0];
      p.pos_z = cz[31:0];
      p.up_y = up[1:0];
      pending.push_back(p);
    endfunction

    function void report(string what, longint got, longint want);
      errors++;
      if (errors <= 40) $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endfunction

    // check one result transfer against the oldest pending pose
    function void check_pose(pose_t got);
      pose_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("result transfer with nothing pending");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.accepted !== want.accepted) report("accepted", got.accepted, want.accepted);
      if (got.moved !== want.moved) report("moved", got.moved, want.moved);
      if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
      if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
      if (got.pos_z !== want.pos_z) report("pos_z", got.pos_z, want.pos_z);
      if (got.up_y !== want.up_y) report("up_y", got.up_y, want.up_y);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic command_i = 0;
  logic [1:0] axis_i = 0;
  logic signed [16:0] delta_angle_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic accepted_o, moved_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [1:0] up_y_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = 0;
  logic [31:0] cfg_data_i = 0;

  pose_board board = new();
  int n_reload, n_rotate, n_invalid;
  bit stall_free;

  orbit_camera_rotate_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .axis_i, .delta_angle_i,
    .out_valid_o, .out_ready_i, .accepted_o, .moved_o, .pos_x_o, .pos_y_o, .pos_z_o,
    .up_y_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // one register write transfer; the block is idle here
  // valid stays up for the next write, write_all drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  task automatic write_all(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                           logic [31:0] rad, logic [31:0] sel, logic [31:0] saz);
    write_reg(RegTargetX, tx);
    write_reg(RegTargetY, ty);
    write_reg(RegTargetZ, tz);
    write_reg(RegRadius, rad);
    write_reg(RegStartEl, sel);
    write_reg(RegStartAz, saz);
    cfg_valid_i <= 0;
  endtask

  // one input transfer, with a random idle gap ahead of it
  // valid is dropped only in a gap or by drain
  task automatic send_command(logic cmd, logic [1:0] ax, logic signed [16:0] delta);
    int g;
    g = stall_free ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    command_i <= cmd;
    axis_i <= ax;
    delta_angle_i <= delta;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_command(cmd, ax, delta);
    if (cmd == CmdReload) n_reload++;
    else if (ax < 2) n_rotate++;
    else n_invalid++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic signed [16:0] rand_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 17'(46080);
    if (r == 1) return -17'sd46080;
    if (r < 5) return 17'($signed($urandom_range(0, 4000)) - 2000);
    return 17'(int'($urandom_range(0, 92160)) - 46080);
  endfunction

  task automatic random_phase(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_command(CmdReload, 2'($urandom), 17'($urandom));
      else if (r < 14) send_command(CmdRotate, 2'($urandom_range(2, 3)), 17'($urandom));
      else send_command(CmdRotate, 2'($urandom_range(0, 1)), rand_angle());
    end
  endtask

  // receiver: random back-pressure, checks each result transfer
  initial begin
    pose_t got;
    int g;
    @(posedge rst_ni);
    forever begin
      g = stall_free ? 0 : gap_len();
      if (g > 0) begin
        out_ready_i <= 0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got = '{accepted_o, moved_o, pos_x_o, pos_y_o, pos_z_o, up_y_o};
      board.check_pose(got);
    end
  end

  // stimulus
  initial begin
    stall_free = 0;
    n_reload = 0; n_rotate = 0; n_invalid = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset state, extremes of angles, invalid axes, straight overhead
    send_command(CmdRotate, 2'd0, 17'sd0);
    send_command(CmdRotate, 2'd0, 17'sd46080);
    send_command(CmdRotate, 2'd0, -17'sd46080);
    send_command(CmdRotate, 2'd0, 17'sd11520);
    send_command(CmdRotate, 2'd0, 17'sd11520);
    send_command(CmdRotate, 2'd0, 17'sd23040);
    send_command(CmdRotate, 2'd0, 17'sd46080);
    send_command(CmdRotate, 2'd1, 17'sd46080);
    send_command(CmdRotate, 2'd1, -17'sd46080);
    send_command(CmdRotate, 2'd1, -17'sd34560);
    send_command(CmdRotate, 2'd2, 17'h1FFFF);
    send_command(CmdRotate, 2'd3, 17'h00000);
    send_command(CmdReload, 2'd3, 17'h1FFFF);
    send_command(CmdRotate, 2'd0, 17'sd11520);
    send_command(CmdRotate, 2'd1, 17'sd23040);
    drain();

    // extreme registers: saturation and radius limits
    write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'(17'sd46080), 32'(-17'sd46080));
    send_command(CmdReload, 2'd0, 17'sd0);
    send_command(CmdRotate, 2'd0, 17'sd11520);
    send_command(CmdRotate, 2'd1, 17'sd23040);
    send_command(CmdRotate, 2'd0, -17'sd34560);
    drain();
    write_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'(-17'sd11520),
              32'(17'sd34560));
    send_command(CmdReload, 2'd1, 17'sd5);
    send_command(CmdRotate, 2'd1, 17'sd100);
    send_command(CmdRotate, 2'd0, 17'sd100);
    drain();

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < 5; ph++) begin
      write_all($urandom, $urandom, $urandom,
                ph == 0 ? 32'h7FFFFFFF : (ph < 3 ? $urandom_range(1, 32'h00400000) : $urandom),
                32'(int'($urandom_range(0, 92160)) - 46080),
                32'(int'($urandom_range(0, 92160)) - 46080));
      send_command(CmdReload, 2'd0, 17'sd0);
      if (ph == 2) begin
        stall_free = 1;
        random_phase(60);
        stall_free = 0;
        random_phase(130);
      end else begin
        random_phase(190);
      end
      // hold off until every pending pose has come back
      drain();
    end

    write_all(32'h0, 32'h0, 32'h0, 32'd65536, 32'h0, 32'h0);
    send_command(CmdReload, 2'd0, 17'sd0);
    drain();

    $display("covered %0d reloads, %0d rotates, %0d invalid axes; %0d results checked",
             n_reload, n_rotate, n_invalid, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("orbit_camera_rotate_unit regression: pass");
    end else begin
      $display("orbit_camera_rotate_unit regression: fail");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #20000000;
    $display("timeout waiting for transfers");
    $display("orbit_camera_rotate_unit regression: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/ocr_pkg.sv
rtl/core/orbit_camera_rotate_unit.sv
test/orbit_camera_rotate_unit_tb.sv
